// File: src/gpkt_pkg.sv
package gpkt_pkg;

    localparam int ID_W    = 23;
    localparam int TIME_W  = 32;
    localparam int GRACE_W = 16;
    localparam int ACT_W   = 2;
    localparam int SLOT_OUT_W = 4;

    localparam logic [GRACE_W-1:0] GRACE_RESET = 16'd10;

    typedef enum logic [ACT_W-1:0] {
        ACT_REGISTERED = 2'd0,
        ACT_PENDING    = 2'd1,
        ACT_FIRED      = 2'd2,
        ACT_OVERFLOW   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    typedef struct packed {
        logic any_hit;
        logic hit_expired;
        logic any_free;
    } chain_t;

    typedef struct packed {
        logic fire;
        logic load;
    } cmd_t;

endpackage

// File: src/gpkt_req_if.sv
interface gpkt_req_if;
    import gpkt_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   request_id;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, output request_id, output now_seconds, input ready);
    modport sink   (input valid, input request_id, input now_seconds, output ready);
endinterface

// File: src/gpkt_rsp_if.sv
interface gpkt_rsp_if;
    import gpkt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [SLOT_OUT_W-1:0] slot;

    modport source (output valid, output action, output slot, input ready);
    modport sink   (input valid, input action, input slot, output ready);
endinterface

// File: src/gpkt_cell.sv
module gpkt_cell #(
    parameter int IDX    = 0,
    parameter int SLOT_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gpkt_pkg::ID_W-1:0]     req_id,
    input  logic [gpkt_pkg::TIME_W-1:0]   req_now,
    input  logic [gpkt_pkg::GRACE_W-1:0]  grace,
    input  gpkt_pkg::cmd_t                cmd,
    input  gpkt_pkg::chain_t              chain_in,
    output gpkt_pkg::chain_t              chain_out,
    input  logic [SLOT_W-1:0]             hit_slot_in,
    output logic [SLOT_W-1:0]             hit_slot_out,
    input  logic [SLOT_W-1:0]             free_slot_in,
    output logic [SLOT_W-1:0]             free_slot_out
);
    import gpkt_pkg::*;

    logic [ID_W-1:0]   entry_id_reg;
    logic [ID_W-1:0]   entry_id_next;
    logic [TIME_W-1:0] entry_time_reg;
    logic [TIME_W-1:0] entry_time_next;
    logic [TIME_W:0]   deadline;
    logic              hit;
    logic              empty;
    logic              expired;
    logic              first_hit;
    logic              first_free;

    assign hit        = (entry_id_reg == req_id);
    assign empty      = (entry_id_reg == '0);
    assign deadline   = {1'b0, entry_time_reg} + {{(TIME_W + 1 - GRACE_W){1'b0}}, grace};
    assign expired    = (deadline < {1'b0, req_now});
    assign first_hit  = hit && !chain_in.any_hit;
    assign first_free = empty && !hit && !chain_in.any_free;

    always_comb
    begin
        chain_out.any_hit     = chain_in.any_hit || hit;
        chain_out.hit_expired = first_hit ? expired : chain_in.hit_expired;
        chain_out.any_free    = chain_in.any_free || first_free;
        hit_slot_out          = first_hit ? SLOT_W'(IDX) : hit_slot_in;
        free_slot_out         = first_free ? SLOT_W'(IDX) : free_slot_in;
    end

    always_comb
    begin
        entry_id_next   = entry_id_reg;
        entry_time_next = entry_time_reg;
        if (cmd.fire && first_hit)
        begin
            entry_id_next   = '0;
            entry_time_next = '0;
        end
        else if (cmd.load && first_free)
        begin
            entry_id_next   = req_id;
            entry_time_next = req_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_id_reg   <= '0;
            entry_time_reg <= '0;
        end
        else
        begin
            entry_id_reg   <= entry_id_next;
            entry_time_reg <= entry_time_next;
        end
    end

endmodule

// File: src/grace_period_kill_table_core.sv
// Grace-period kill table. Each request beat on req carries a nonzero request_id and the
// current time now_seconds; one response beat on rsp answers it with action and slot
// (0 registered in the lowest free slot, 1 already pending, 2 expired and fired with the
// slot freed, 3 overflow or zero id with slot 0). An entry fires when its stored time plus
// grace_seconds is strictly below now_seconds, with no timestamp wrap handling. The table is
// a row of TABLE_ENTRIES cells that all compare the captured request in the same cycle and
// pass hit and free flags down the row to resolve the lowest matching and free slots.
// A request is captured in S_IDLE, then resolved by the cell row and committed in S_EVAL, which holds
// while the response register is stalled. The table is empty after reset. grace_seconds resets to 10
// and is written through cfg_we/cfg_wdata; the user must write it only while idle, the block does not enforce it.
module grace_period_kill_table_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gpkt_pkg::GRACE_W-1:0]  cfg_wdata,
    gpkt_req_if.sink                      req,
    gpkt_rsp_if.source                    rsp
);
    import gpkt_pkg::*;

    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    state_t              state_reg;
    state_t              state_next;
    logic [GRACE_W-1:0]  grace_reg;
    logic [ID_W-1:0]     req_id_reg;
    logic [TIME_W-1:0]   req_now_reg;
    logic                out_valid_reg;
    action_t             action_reg;
    action_t             action_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic                accept;
    logic                commit;
    logic                id_zero;
    cmd_t                cmd;

    chain_t              link      [0:TABLE_ENTRIES];
    logic [SLOT_W-1:0]   hit_link  [0:TABLE_ENTRIES];
    logic [SLOT_W-1:0]   free_link [0:TABLE_ENTRIES];

    assign link[0]      = '0;
    assign hit_link[0]  = '0;
    assign free_link[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        gpkt_cell #(
            .IDX    (i),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .req_id        (req_id_reg),
            .req_now       (req_now_reg),
            .grace         (grace_reg),
            .cmd           (cmd),
            .chain_in      (link[i]),
            .chain_out     (link[i+1]),
            .hit_slot_in   (hit_link[i]),
            .hit_slot_out  (hit_link[i+1]),
            .free_slot_in  (free_link[i]),
            .free_slot_out (free_link[i+1])
        );
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign commit     = (state_reg == S_EVAL) && (!out_valid_reg || rsp.ready);
    assign id_zero    = (req_id_reg == '0);

    assign rsp.valid  = out_valid_reg;
    assign rsp.action = action_reg;
    assign rsp.slot   = SLOT_OUT_W'(slot_reg);

    always_comb
    begin
        action_next = ACT_OVERFLOW;
        slot_next   = '0;
        cmd         = '0;
        if (id_zero)
        begin
            action_next = ACT_OVERFLOW;
        end
        else if (link[TABLE_ENTRIES].any_hit && link[TABLE_ENTRIES].hit_expired)
        begin
            action_next = ACT_FIRED;
            slot_next   = hit_link[TABLE_ENTRIES];
            cmd.fire    = commit;
        end
        else if (link[TABLE_ENTRIES].any_hit)
        begin
            action_next = ACT_PENDING;
            slot_next   = hit_link[TABLE_ENTRIES];
        end
        else if (link[TABLE_ENTRIES].any_free)
        begin
            action_next = ACT_REGISTERED;
            slot_next   = free_link[TABLE_ENTRIES];
            cmd.load    = commit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grace_reg     <= GRACE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                grace_reg <= cfg_wdata;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_id_reg  <= req.request_id;
            req_now_reg <= req.now_seconds;
        end
        if (commit)
        begin
            action_reg <= action_next;
            slot_reg   <= slot_next;
        end
    end

    a_fire_needs_hit : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> (link[TABLE_ENTRIES].any_hit && !id_zero))
        else $error("fire without a matching entry");

    a_load_needs_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (link[TABLE_ENTRIES].any_free && !link[TABLE_ENTRIES].any_hit && !id_zero))
        else $error("register without a free slot or with a duplicate");

    a_commit_shows_beat : assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("committed result not presented");

    a_overflow_slot_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg == ACT_OVERFLOW) |-> (slot_reg == '0))
        else $error("overflow with nonzero slot");

    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EVAL && !req.ready))
        else $error("second request taken while one is in flight");

endmodule
